### rtl/core/cee_pkg.sv
// Shared types and constants for the covariance error ellipse unit.
// No dependencies; cee_cordic, the top level and cee_checker import this package.
package cee_pkg;

    localparam int PADDR_W      = 3;
    localparam int REG_IDX_LSB  = 2;
    localparam logic REG_COVERAGE_SCALE = 1'b0;

    localparam int COVERAGE_W = 24;
    localparam logic [COVERAGE_W-1:0] COVERAGE_RESET = 24'd196334;

    localparam int COORD_W = 32;
    localparam int ANGLE_W = 18;

    // Angle datapath
    localparam int NORM_W       = 40;
    localparam int NORM_STEPS   = 6;
    localparam int CORDIC_STEPS = 30;
    localparam int CORDIC_W     = 44;
    localparam int ZACC_W       = 33;
    localparam int CORDIC_LAT   = NORM_STEPS + 1 + CORDIC_STEPS + 1;

    localparam logic signed [ZACC_W-1:0] HALF_PI_Q30  = 33'sd1686629713;
    localparam logic signed [ZACC_W:0]   ORIENT_LIMIT = 34'sd102944;

    localparam logic [31:0] ATAN_TAB [0:CORDIC_STEPS-1] = '{
        32'd843314857, 32'd497837829, 32'd263043837, 32'd133525159, 32'd67021687,
        32'd33543516,  32'd16775851,  32'd8388437,   32'd4194283,   32'd2097149,
        32'd1048576,   32'd524288,    32'd262144,    32'd131072,    32'd65536,
        32'd32768,     32'd16384,     32'd8192,      32'd4096,      32'd2048,
        32'd1024,      32'd512,       32'd256,       32'd128,       32'd64,
        32'd32,        32'd16,        32'd8,         32'd4,         32'd2
    };

    typedef struct packed {
        logic signed [COORD_W-1:0] center_x;
        logic signed [COORD_W-1:0] center_y;
        logic signed [ANGLE_W-1:0] orientation;
        logic [COORD_W-1:0]        radius_major;
        logic [COORD_W-1:0]        radius_minor;
    } ell_beat_t;

endpackage

### rtl/core/cee_stream_if.sv
// Valid/ready stream interfaces for hypothesis input beats and ellipse output beats.
// Standalone; no package dependency.
interface cee_hyp_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] mean_x;
    logic signed [31:0] mean_y;
    logic [31:0]        cov_xx;
    logic [31:0]        cov_yy;
    logic signed [31:0] cov_xy;

    modport source (output valid, mean_x, mean_y, cov_xx, cov_yy, cov_xy, input ready);
    modport sink   (input valid, mean_x, mean_y, cov_xx, cov_yy, cov_xy, output ready);
endinterface

interface cee_ell_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] center_x;
    logic signed [31:0] center_y;
    logic signed [17:0] orientation;
    logic [31:0]        radius_major;
    logic [31:0]        radius_minor;

    modport source (output valid, center_x, center_y, orientation, radius_major,
                    radius_minor, input ready);
    modport sink   (input valid, center_x, center_y, orientation, radius_major,
                    radius_minor, output ready);
endinterface

### rtl/core/cee_delay.sv
// Enabled delay line for payload that rides alongside the pipeline.
// No package dependency.
module cee_delay #(
    parameter int W     = 1,
    parameter int DEPTH = 2
) (
    input  logic         clk,
    input  logic         en,
    input  logic [W-1:0] d,
    output logic [W-1:0] q
);
    logic [W-1:0] tap_reg [0:DEPTH-1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tap_reg[0] <= d;
            for (int i = 1; i < DEPTH; i++)
            begin
                tap_reg[i] <= tap_reg[i-1];
            end
        end
    end

    assign q = tap_reg[DEPTH-1];
endmodule

### rtl/core/cee_isqrt.sv
// Pipelined floor square root, one result bit resolved per register stage.
// No package dependency.
module cee_isqrt #(
    parameter int IN_W  = 64,
    parameter int OUT_W = 32
) (
    input  logic             clk,
    input  logic             en,
    input  logic [IN_W-1:0]  radicand,
    output logic [OUT_W-1:0] root
);
    localparam int TW = ((IN_W > 2 * OUT_W) ? IN_W : 2 * OUT_W) + 1;

    logic [TW-1:0]    rem_tap  [0:OUT_W];
    logic [OUT_W-1:0] root_tap [0:OUT_W];

    assign rem_tap[0]  = {{(TW-IN_W){1'b0}}, radicand};
    assign root_tap[0] = '0;

    for (genvar s = 0; s < OUT_W; s++)
    begin : g_stage
        localparam int B = OUT_W - 1 - s;
        logic [TW-1:0]    trial;
        logic             take;
        logic [TW-1:0]    rem_next;
        logic [OUT_W-1:0] root_next;
        logic [TW-1:0]    rem_reg;
        logic [OUT_W-1:0] root_reg;

        // Setting bit B grows root^2 by 2^(B+1)*root + 2^(2B).
        always_comb
        begin
            trial     = ({{(TW-OUT_W){1'b0}}, root_tap[s]} << (B + 1))
                      | (TW'(1) << (2 * B));
            take      = rem_tap[s] >= trial;
            rem_next  = take ? rem_tap[s] - trial : rem_tap[s];
            root_next = take ? (root_tap[s] | (OUT_W'(1) << B)) : root_tap[s];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg  <= rem_next;
                root_reg <= root_next;
            end
        end

        assign rem_tap[s+1]  = rem_reg;
        assign root_tap[s+1] = root_reg;
    end

    assign root = root_tap[OUT_W];
endmodule

### rtl/core/cee_cordic.sv
// Pipelined vectoring CORDIC giving the half angle of (x, y) in signed Q2.16.
// Depends on cee_pkg for the arctangent table and widths.
module cee_cordic (
    input  logic                          clk,
    input  logic                          en,
    input  logic signed [32:0]            x_in,
    input  logic signed [32:0]            y_in,
    output logic signed [cee_pkg::ANGLE_W-1:0] angle
);
    import cee_pkg::*;

    // Normalizing shifter: a binary search over shift amounts 32..1.
    logic [NORM_W-1:0] mx_tap [0:NORM_STEPS];
    logic [NORM_W-1:0] my_tap [0:NORM_STEPS];
    logic              sx_tap [0:NORM_STEPS];
    logic              sy_tap [0:NORM_STEPS];
    logic              zero_tap [0:NORM_STEPS];
    logic [32:0]       ax;
    logic [32:0]       ay;

    always_comb
    begin
        ax = x_in[32] ? 33'(-x_in) : 33'(x_in);
        ay = y_in[32] ? 33'(-y_in) : 33'(y_in);
    end

    assign mx_tap[0]   = {{(NORM_W-33){1'b0}}, ax};
    assign my_tap[0]   = {{(NORM_W-33){1'b0}}, ay};
    assign sx_tap[0]   = x_in[32];
    assign sy_tap[0]   = y_in[32];
    assign zero_tap[0] = (x_in == '0) && (y_in == '0);

    for (genvar j = 0; j < NORM_STEPS; j++)
    begin : g_norm
        localparam int SH = 32 >> j;
        logic [NORM_W-1:0] m;
        logic              fits;
        logic [NORM_W-1:0] mx_reg;
        logic [NORM_W-1:0] my_reg;
        logic              sx_reg;
        logic              sy_reg;
        logic              zero_reg;

        always_comb
        begin
            m    = (mx_tap[j] > my_tap[j]) ? mx_tap[j] : my_tap[j];
            fits = (m >> (NORM_W - SH)) == '0;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                mx_reg   <= fits ? (mx_tap[j] << SH) : mx_tap[j];
                my_reg   <= fits ? (my_tap[j] << SH) : my_tap[j];
                sx_reg   <= sx_tap[j];
                sy_reg   <= sy_tap[j];
                zero_reg <= zero_tap[j];
            end
        end

        assign mx_tap[j+1]   = mx_reg;
        assign my_tap[j+1]   = my_reg;
        assign sx_tap[j+1]   = sx_reg;
        assign sy_tap[j+1]   = sy_reg;
        assign zero_tap[j+1] = zero_reg;
    end

    // Left half-plane vectors get a quarter turn first.
    logic signed [CORDIC_W-1:0] x_tap [0:CORDIC_STEPS];
    logic signed [CORDIC_W-1:0] y_tap [0:CORDIC_STEPS];
    logic signed [ZACC_W-1:0]   z_tap [0:CORDIC_STEPS];
    logic                       zc_tap [0:CORDIC_STEPS];
    logic signed [CORDIC_W-1:0] xm;
    logic signed [CORDIC_W-1:0] ym;
    logic signed [CORDIC_W-1:0] x0_reg;
    logic signed [CORDIC_W-1:0] y0_reg;
    logic signed [ZACC_W-1:0]   z0_reg;
    logic                       zero0_reg;

    always_comb
    begin
        xm = $signed({{(CORDIC_W-NORM_W){1'b0}}, mx_tap[NORM_STEPS]});
        ym = $signed({{(CORDIC_W-NORM_W){1'b0}}, my_tap[NORM_STEPS]});
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            zero0_reg <= zero_tap[NORM_STEPS];
            if (!sx_tap[NORM_STEPS])
            begin
                x0_reg <= xm;
                y0_reg <= sy_tap[NORM_STEPS] ? -ym : ym;
                z0_reg <= '0;
            end
            else if (!sy_tap[NORM_STEPS])
            begin
                x0_reg <= ym;
                y0_reg <= xm;
                z0_reg <= HALF_PI_Q30;
            end
            else
            begin
                x0_reg <= ym;
                y0_reg <= -xm;
                z0_reg <= -HALF_PI_Q30;
            end
        end
    end

    assign x_tap[0]  = x0_reg;
    assign y_tap[0]  = y0_reg;
    assign z_tap[0]  = z0_reg;
    assign zc_tap[0] = zero0_reg;

    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_iter
        logic signed [ZACC_W-1:0]   atn;
        logic signed [CORDIC_W-1:0] x_reg;
        logic signed [CORDIC_W-1:0] y_reg;
        logic signed [ZACC_W-1:0]   z_reg;
        logic                       zero_reg;

        assign atn = $signed({1'b0, ATAN_TAB[i]});

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                zero_reg <= zc_tap[i];
                if (!y_tap[i][CORDIC_W-1])
                begin
                    x_reg <= x_tap[i] + (y_tap[i] >>> i);
                    y_reg <= y_tap[i] - (x_tap[i] >>> i);
                    z_reg <= z_tap[i] + atn;
                end
                else
                begin
                    x_reg <= x_tap[i] - (y_tap[i] >>> i);
                    y_reg <= y_tap[i] + (x_tap[i] >>> i);
                    z_reg <= z_tap[i] - atn;
                end
            end
        end

        assign x_tap[i+1]  = x_reg;
        assign y_tap[i+1]  = y_reg;
        assign z_tap[i+1]  = z_reg;
        assign zc_tap[i+1] = zero_reg;
    end

    // Halve, round to nearest with ties up, and clamp to a quarter turn.
    logic signed [ZACC_W:0]    ang_wide;
    logic signed [ANGLE_W-1:0] angle_next;
    logic signed [ANGLE_W-1:0] angle_reg;

    always_comb
    begin
        ang_wide = ($signed({z_tap[CORDIC_STEPS][ZACC_W-1], z_tap[CORDIC_STEPS]})
                   + 34'sd16384) >>> 15;
        if (zc_tap[CORDIC_STEPS])
            angle_next = '0;
        else if (ang_wide > ORIENT_LIMIT)
            angle_next = ORIENT_LIMIT[ANGLE_W-1:0];
        else if (ang_wide < -ORIENT_LIMIT)
            angle_next = ANGLE_W'(-ORIENT_LIMIT);
        else
            angle_next = ang_wide[ANGLE_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
            angle_reg <= angle_next;
    end

    assign angle = angle_reg;
endmodule

### rtl/core/covariance_error_ellipse_2d_unit.sv
// Uncertainty ellipse of a 2D pose hypothesis: top level with APB register port.
// Depends on cee_pkg, cee_stream_if, cee_delay, cee_isqrt and cee_cordic.
//
// The unit takes one hypothesis beat per clock cycle while the output buffer
// has room and returns one ellipse beat for each, in order. From acceptance
// until its result is offered, a beat passes through the two chained square-root
// pipelines, each resolving one root bit per stage (34 stages for the
// eigenvalue spread t, then 30 for the radii), with the multiply, add and
// radicand stages between them. The angle runs through a normalizing shifter
// and a 30-stage vectoring CORDIC in parallel. The whole pipeline advances as
// one, and a two-beat output buffer decouples it from the consumer: input
// ready depends only on that buffer's fill, so a result can wait while new
// beats keep entering, and a sustained stall costs nothing but throughput.
// coverage_scale (Q8.16, byte address 0) is the chi-square scale -ln(1-p);
// change it only while no beat is in flight. Radii cannot exceed 2^30 at
// these field widths, so no saturation is visible on the outputs.
module covariance_error_ellipse_2d_unit (
    input  logic                         clk,
    input  logic                         rst_n,
    cee_hyp_if.sink                      hyp,
    cee_ell_if.source                    ell,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [cee_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);
    import cee_pkg::*;

    localparam int T_W    = 34;
    localparam int RAD_W  = 30;
    localparam int SUM_W  = 33;
    localparam int S_W    = 35;
    localparam int PROD_W = COVERAGE_W + S_W;
    localparam int D_W    = 67;
    localparam int LAT    = 3 + T_W + 2 + RAD_W;

    // Register port
    logic [COVERAGE_W-1:0] coverage_scale_reg;

    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            coverage_scale_reg <= COVERAGE_RESET;
        else if (psel && penable && pwrite
                 && (paddr[REG_IDX_LSB] == REG_COVERAGE_SCALE))
            coverage_scale_reg <= pwdata[COVERAGE_W-1:0];
    end

    always_comb
    begin
        if (paddr[REG_IDX_LSB] == REG_COVERAGE_SCALE)
            prdata = {{(32-COVERAGE_W){1'b0}}, coverage_scale_reg};
        else
            prdata = '0;
    end

    // Pipeline control: everything moves together while the output buffer has room.
    logic           adv;
    logic [1:0]     count_reg;
    logic [LAT-1:0] valid_reg;

    assign adv       = count_reg != 2'd2;
    assign hyp.ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (adv)
            valid_reg <= {valid_reg[LAT-2:0], hyp.valid};
    end

    // Stage 1: differences, sums and magnitudes.
    logic [31:0]        dx_next;
    logic [31:0]        axy_abs;
    logic [31:0]        dx_reg;
    logic [32:0]        axy2_reg;
    logic [SUM_W-1:0]   sum_reg;
    logic signed [32:0] xdiff_reg;
    logic signed [32:0] y2_reg;
    logic [63:0]        mean_reg;

    always_comb
    begin
        dx_next = (hyp.cov_xx >= hyp.cov_yy) ? hyp.cov_xx - hyp.cov_yy
                                             : hyp.cov_yy - hyp.cov_xx;
        axy_abs = hyp.cov_xy[31] ? 32'(-hyp.cov_xy) : 32'(hyp.cov_xy);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dx_reg    <= dx_next;
            axy2_reg  <= {axy_abs, 1'b0};
            sum_reg   <= {1'b0, hyp.cov_xx} + {1'b0, hyp.cov_yy};
            xdiff_reg <= $signed({1'b0, hyp.cov_xx}) - $signed({1'b0, hyp.cov_yy});
            y2_reg    <= $signed({hyp.cov_xy, 1'b0});
            mean_reg  <= {hyp.mean_x, hyp.mean_y};
        end
    end

    // Stages 2 and 3: squares and their sum.
    logic [63:0]    p1_reg;
    logic [65:0]    p2_reg;
    logic [D_W-1:0] d_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p1_reg <= dx_reg * dx_reg;
            p2_reg <= axy2_reg * axy2_reg;
            d_reg  <= {3'b000, p1_reg} + {1'b0, p2_reg};
        end
    end

    logic [T_W-1:0] t_root;

    cee_isqrt #(.IN_W(D_W), .OUT_W(T_W)) u_sqrt_t (
        .clk      (clk),
        .en       (adv),
        .radicand (d_reg),
        .root     (t_root)
    );

    logic [SUM_W-1:0] sum_d;

    cee_delay #(.W(SUM_W), .DEPTH(T_W + 2)) u_sum_dly (
        .clk (clk),
        .en  (adv),
        .d   (sum_reg),
        .q   (sum_d)
    );

    // Radicands: the minor one clamps at zero when the matrix is not semidefinite.
    logic [S_W-1:0]    smaj_reg;
    logic [S_W-1:0]    smin_reg;
    logic [PROD_W-1:0] pmaj_reg;
    logic [PROD_W-1:0] pmin_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            smaj_reg <= {2'b00, sum_d} + {1'b0, t_root};
            smin_reg <= ({1'b0, sum_d} >= t_root) ? S_W'({1'b0, sum_d} - t_root) : '0;
            pmaj_reg <= coverage_scale_reg * smaj_reg;
            pmin_reg <= coverage_scale_reg * smin_reg;
        end
    end

    logic [RAD_W-1:0] rmaj;
    logic [RAD_W-1:0] rmin;

    cee_isqrt #(.IN_W(PROD_W), .OUT_W(RAD_W)) u_sqrt_major (
        .clk      (clk),
        .en       (adv),
        .radicand (pmaj_reg),
        .root     (rmaj)
    );

    cee_isqrt #(.IN_W(PROD_W), .OUT_W(RAD_W)) u_sqrt_minor (
        .clk      (clk),
        .en       (adv),
        .radicand (pmin_reg),
        .root     (rmin)
    );

    // Orientation path, padded to line up with the radii.
    logic signed [ANGLE_W-1:0] angle;
    logic [ANGLE_W-1:0]        angle_d;
    logic [63:0]               mean_d;

    cee_cordic u_cordic (
        .clk   (clk),
        .en    (adv),
        .x_in  (xdiff_reg),
        .y_in  (y2_reg),
        .angle (angle)
    );

    cee_delay #(.W(ANGLE_W), .DEPTH(LAT - 1 - CORDIC_LAT)) u_angle_dly (
        .clk (clk),
        .en  (adv),
        .d   (angle),
        .q   (angle_d)
    );

    cee_delay #(.W(64), .DEPTH(LAT - 1)) u_mean_dly (
        .clk (clk),
        .en  (adv),
        .d   (mean_reg),
        .q   (mean_d)
    );

    // Two-beat output buffer.
    ell_beat_t push_beat;
    ell_beat_t buf_reg [0:1];
    logic      wr_ptr_reg;
    logic      rd_ptr_reg;
    logic      push;
    logic      pop;

    always_comb
    begin
        push_beat.center_x     = $signed(mean_d[63:32]);
        push_beat.center_y     = $signed(mean_d[31:0]);
        push_beat.orientation  = $signed(angle_d);
        push_beat.radius_major = {{(COORD_W-RAD_W){1'b0}}, rmaj};
        push_beat.radius_minor = {{(COORD_W-RAD_W){1'b0}}, rmin};
    end

    assign push = adv && valid_reg[LAT-1];
    assign pop  = ell.valid && ell.ready;

    always_ff @(posedge clk)
    begin
        if (push)
            buf_reg[wr_ptr_reg] <= push_beat;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            if (push && !pop)
                count_reg <= count_reg + 2'd1;
            else if (pop && !push)
                count_reg <= count_reg - 2'd1;
        end
    end

    assign ell.valid        = count_reg != 2'd0;
    assign ell.center_x     = buf_reg[rd_ptr_reg].center_x;
    assign ell.center_y     = buf_reg[rd_ptr_reg].center_y;
    assign ell.orientation  = buf_reg[rd_ptr_reg].orientation;
    assign ell.radius_major = buf_reg[rd_ptr_reg].radius_major;
    assign ell.radius_minor = buf_reg[rd_ptr_reg].radius_minor;
endmodule

### rtl/core/cee_checker.sv
// Port-level checks for the covariance error ellipse unit, bound to the top level.
// Depends on cee_pkg and the top level module.
module cee_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        ell_valid,
    input logic                        ell_ready,
    input logic signed [17:0]          ell_orientation,
    input logic [31:0]                 ell_radius_major,
    input logic [31:0]                 ell_radius_minor,
    input logic                        psel,
    input logic                        penable,
    input logic                        pwrite,
    input logic                        pready,
    input logic [cee_pkg::PADDR_W-1:0] paddr,
    input logic [31:0]                 pwdata,
    input logic [31:0]                 prdata
);
    import cee_pkg::*;

    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        ell_valid && !ell_ready |=> ell_valid)
        else $error("output beat withdrawn before it was taken");

    a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
        ell_valid |-> (ell_orientation <= 18'sd102944) && (ell_orientation >= -18'sd102944))
        else $error("orientation outside a quarter turn");

    a_radius_order: assert property (@(posedge clk) disable iff (!rst_n)
        ell_valid |-> ell_radius_minor <= ell_radius_major)
        else $error("minor radius exceeds major radius");

    a_reg_readback: assert property (@(posedge clk) disable iff (!rst_n)
        (psel && penable && pwrite && pready && (paddr[REG_IDX_LSB] == REG_COVERAGE_SCALE))
        ##1 (paddr[REG_IDX_LSB] == REG_COVERAGE_SCALE)
        |-> prdata == {8'h00, $past(pwdata[COVERAGE_W-1:0])})
        else $error("coverage_scale readback does not match last write");
endmodule

bind covariance_error_ellipse_2d_unit cee_checker u_cee_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .ell_valid        (ell.valid),
    .ell_ready        (ell.ready),
    .ell_orientation  (ell.orientation),
    .ell_radius_major (ell.radius_major),
    .ell_radius_minor (ell.radius_minor),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .pready           (pready),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata)
);

### tb/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for covariance_error_ellipse_2d_unit: hypothesis beats in,
// ellipse beats checked against an in-bench fixed-point predictor.
// Depends on cee_pkg, cee_stream_if and the unit's RTL.
module testbench;
    import cee_pkg::*;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    cee_hyp_if hyp ();
    cee_ell_if ell ();

    covariance_error_ellipse_2d_unit uut (
        .clk(clk), .rst_n(rst_n), .hyp(hyp), .ell(ell),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #1 clk = ~clk;

    // Idle percentages of the sender and the receiver; changed between phases.
    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;

    logic [23:0] coverage_k = COVERAGE_RESET;
    ell_beat_t ellipse_queue[$];
    int unsigned failures = 0;
    longint unsigned cycle_count = 0;

    localparam longint unsigned CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 100;

    // Floor square root of a value below 2^68; the root fits in 34 bits.
    function automatic logic [33:0] root_floor(input logic [67:0] v);
        logic [33:0] r;
        logic [33:0] c;
        r = '0;
        for (int b = 33; b >= 0; b--)
        begin
            c = r | (34'd1 << b);
            if ({34'd0, c} * {34'd0, c} <= v)
                r = c;
        end
        return r;
    endfunction

    // Vectoring CORDIC on (dx, dy): a halved angle in Q2.16, clamped to +-pi/2.
    function automatic logic signed [17:0] half_angle(input longint x, input longint y);
        longint unsigned mx;
        longint unsigned my;
        longint unsigned m;
        longint z;
        longint nx;
        longint ny;
        longint sx;
        longint sy;
        longint ang;
        int sh;
        if (x == 0 && y == 0)
            return '0;
        mx = (x < 0) ? -x : x;
        my = (y < 0) ? -y : y;
        m = (mx > my) ? mx : my;
        sh = 0;
        while ((m << sh) < (64'd1 << 39))
            sh++;
        x = (x < 0) ? -longint'(mx << sh) : longint'(mx << sh);
        y = (y < 0) ? -longint'(my << sh) : longint'(my << sh);
        z = 0;
        // A vector in the left half-plane is turned a quarter turn first.
        if (x < 0)
        begin
            if (y >= 0)
            begin
                nx = y; ny = -x; z = HALF_PI_Q30;
            end
            else
            begin
                nx = -y; ny = x; z = -longint'(HALF_PI_Q30);
            end
            x = nx; y = ny;
        end
        for (int i = 0; i < CORDIC_STEPS; i++)
        begin
            sx = y >>> i;
            sy = x >>> i;
            if (y >= 0)
            begin
                x += sx; y -= sy; z += ATAN_TAB[i];
            end
            else
            begin
                x -= sx; y += sy; z -= ATAN_TAB[i];
            end
        end
        ang = (z + (longint'(1) << 14)) >>> 15;
        if (ang > 102944)
            ang = 102944;
        if (ang < -102944)
            ang = -102944;
        return ang[17:0];
    endfunction

    function automatic logic [31:0] scaled_radius(input logic [23:0] k, input logic [33:0] s);
        logic [33:0] r;
        r = root_floor({44'd0, k} * {34'd0, s});
        return (r > 34'hFFFF_FFFF) ? 32'hFFFF_FFFF : r[31:0];
    endfunction

    function automatic ell_beat_t predict_ellipse(input logic [31:0] mx, input logic [31:0] my,
                                                  input logic [31:0] xx, input logic [31:0] yy,
                                                  input logic [31:0] xy);
        ell_beat_t e;
        logic [31:0] dxy;
        logic [32:0] axy2;
        logic [67:0] radicand;
        logic [33:0] spread;
        logic [33:0] sum;
        logic [33:0] smin;
        longint xy_s;
        dxy = (xx >= yy) ? xx - yy : yy - xx;
        xy_s = longint'($signed(xy));
        axy2 = (xy_s < 0) ? 33'(-xy_s) << 1 : 33'(xy_s) << 1;
        radicand = {36'd0, dxy} * {36'd0, dxy} + {35'd0, axy2} * {35'd0, axy2};
        spread = root_floor(radicand);
        sum = {2'b0, xx} + {2'b0, yy};
        smin = (sum >= spread) ? sum - spread : '0;
        e.center_x = mx;
        e.center_y = my;
        e.orientation = half_angle(longint'(xx) - longint'(yy), 2 * xy_s);
        e.radius_major = scaled_radius(coverage_k, sum + spread);
        e.radius_minor = scaled_radius(coverage_k, smin);
        return e;
    endfunction

    // Sends one hypothesis beat and records its predicted ellipse on acceptance.
    // Valid stays high after the beat so that back-to-back beats leave no gap.
    task automatic send_hypothesis(input logic [31:0] mx, input logic [31:0] my,
                                   input logic [31:0] xx, input logic [31:0] yy,
                                   input logic [31:0] xy);
        while ($urandom_range(99) < send_idle_pct)
        begin
            hyp.valid <= 1'b0;
            @(negedge clk);
        end
        hyp.valid <= 1'b1;
        hyp.mean_x <= mx;
        hyp.mean_y <= my;
        hyp.cov_xx <= xx;
        hyp.cov_yy <= yy;
        hyp.cov_xy <= xy;
        do
            @(posedge clk);
        while (!hyp.ready);
        ellipse_queue.push_back(predict_ellipse(mx, my, xx, yy, xy));
        @(negedge clk);
    endtask

    // Stops sending, waits for every expected ellipse, then lets the pipeline settle.
    task automatic wait_drained();
        hyp.valid <= 1'b0;
        while (ellipse_queue.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_coverage(input logic [23:0] k);
        wait_drained();
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= PADDR_W'(REG_COVERAGE_SCALE) << REG_IDX_LSB;
        pwdata <= {8'd0, k};
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        coverage_k = k;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // Checker: compares each accepted ellipse beat with the oldest prediction.
    always @(posedge clk)
    begin
        ell_beat_t want;
        cycle_count <= cycle_count + 1;
        if (rst_n && ell.valid && ell.ready)
        begin
            if (ellipse_queue.size() == 0)
            begin
                $display("%0t: ellipse beat with none expected", $time);
                failures++;
            end
            else
            begin
                want = ellipse_queue.pop_front();
                if (ell.center_x !== want.center_x || ell.center_y !== want.center_y ||
                    ell.orientation !== want.orientation ||
                    ell.radius_major !== want.radius_major ||
                    ell.radius_minor !== want.radius_minor)
                begin
                    $display("%0t: expected cx %h cy %h ang %h rmaj %h rmin %h", $time,
                             want.center_x, want.center_y, want.orientation,
                             want.radius_major, want.radius_minor);
                    $display("%0t: actual   cx %h cy %h ang %h rmaj %h rmin %h", $time,
                             ell.center_x, ell.center_y, ell.orientation,
                             ell.radius_major, ell.radius_minor);
                    failures++;
                end
            end
        end
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Receiver stalls at random, changed on the falling edge.
    always @(negedge clk)
        ell.ready <= ($urandom_range(99) >= recv_idle_pct);

    // Directed corners: extreme fields, zero vector, negative x axis, and
    // a matrix that is not positive semidefinite.
    task automatic test_directed();
        send_hypothesis(32'h8000_0000, 32'h7FFF_FFFF, 32'd0, 32'd0, 32'd0);
        send_hypothesis(32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000, 32'h0001_0000, 32'd0);
        send_hypothesis(32'd0, 32'hFFFF_FFFF, 32'h0001_0000, 32'h0004_0000, 32'd0);
        send_hypothesis(32'd1, 32'd2, 32'h0004_0000, 32'h0001_0000, 32'd0);
        send_hypothesis(32'd3, 32'd4, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
        send_hypothesis(32'd5, 32'd6, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000);
        send_hypothesis(32'd7, 32'd8, 32'hFFFF_FFFF, 32'd0, 32'd0);
        send_hypothesis(32'd9, 32'd10, 32'd0, 32'hFFFF_FFFF, 32'd0);
        send_hypothesis(32'd11, 32'd12, 32'd0, 32'd0, 32'h8000_0000);
        send_hypothesis(32'd13, 32'd14, 32'd0, 32'd0, 32'h7FFF_FFFF);
        send_hypothesis(32'd15, 32'd16, 32'd1, 32'd1, 32'hFFFF_FFFF);
        send_hypothesis(32'd17, 32'd18, 32'd1, 32'd0, 32'd1);
        send_hypothesis(32'd19, 32'd20, 32'd0, 32'd1, 32'hFFFF_FFFF);
        send_hypothesis(32'd21, 32'd22, 32'h0001_0000, 32'h0001_0000, 32'h0010_0000);
        send_hypothesis(32'd23, 32'd24, 32'h0002_0000, 32'h0001_0000, 32'hFFF0_0000);
    endtask

    // Coverage scale at its extremes: zero gives zero radii, full scale is largest.
    task automatic test_scale_extremes();
        write_coverage(24'd0);
        send_hypothesis(32'd1, 32'd1, 32'hFFFF_FFFF, 32'h1234_5678, 32'h4000_0000);
        send_hypothesis(32'd2, 32'd2, 32'h0001_0000, 32'h0002_0000, 32'd0);
        write_coverage(24'hFF_FFFF);
        send_hypothesis(32'd3, 32'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
        send_hypothesis(32'd4, 32'd4, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0);
        send_hypothesis(32'd5, 32'd5, 32'd1, 32'd1, 32'd0);
    endtask

    // Random hypotheses; mostly plausible matrices, with raw noise mixed in.
    task automatic test_random(input int count);
        logic [31:0] xx;
        logic [31:0] yy;
        logic [31:0] xy;
        int sh;
        for (int n = 0; n < count; n++)
        begin
            sh = $urandom_range(31);
            xx = $urandom >> sh;
            yy = $urandom >> $urandom_range(31);
            xy = $urandom;
            case ($urandom_range(5))
                0: xy = '0;
                1: yy = xx;
                2: xy = $signed(xy) >>> $urandom_range(31);
                default: ;
            endcase
            send_hypothesis($urandom, $urandom, xx, yy, xy);
        end
    endtask

    initial
    begin
        hyp.valid = 1'b0;
        hyp.mean_x = '0;
        hyp.mean_y = '0;
        hyp.cov_xx = '0;
        hyp.cov_yy = '0;
        hyp.cov_xy = '0;
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_idle_pct = 33;
        recv_idle_pct = 53;
        test_directed();
        test_random(500);
        test_scale_extremes();

        send_idle_pct = 53;
        recv_idle_pct = 33;
        write_coverage(24'($urandom_range(24'hFF_FFFF)));
        test_random(500);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_coverage(COVERAGE_RESET);
        test_random(550);

        wait_drained();
        if (failures == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule
